// ===== hw/rtl/qwsc_pkg.sv =====
// Types and constants shared by the wheel speed controller files.
package qwsc_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SPEED_SCALE      = 2'd0,
    REG_SPEED_LOOP_GAIN  = 2'd1,
    REG_ACCEL_ERROR_GAIN = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SAT,
    ST_MUL1,
    ST_ERR,
    ST_MUL2,
    ST_ACC,
    ST_MUL3,
    ST_MAG,
    ST_DRV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              encoder_line;
    logic              pin_level;
    logic signed [7:0] target_speed;
  } item_t;

  typedef struct packed {
    logic signed [19:0] measured_speed;
    logic signed [31:0] distance;
    logic               drive_forward;
    logic               drive_reverse;
    logic [6:0]         duty_percent;
  } result_t;

  // Shift-add multiplier geometry: signed multiplicand, unsigned Q8.8 multiplier
  localparam int MC_W   = 48;
  localparam int MP_W   = 16;
  localparam int PROD_W = MC_W + MP_W;

  typedef struct packed {
    logic                   start;
    logic signed [MC_W-1:0] mcand;
    logic [MP_W-1:0]        mplier;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  localparam logic [15:0] SPEED_SCALE_RST      = 16'd384;
  localparam logic [15:0] SPEED_LOOP_GAIN_RST  = 16'd384;
  localparam logic [15:0] ACCEL_ERROR_GAIN_RST = 16'd205;

  localparam int SUM_MAX = 524287;
  localparam int SUM_MIN = -524288;

  localparam logic signed [7:0] TARGET_MAX = 8'sd100;
  localparam logic signed [7:0] TARGET_MIN = -8'sd100;

  localparam logic [39:0] BRAKE_LIMIT = 40'd10;
  localparam logic [39:0] MAX_DUTY_W  = 40'd100;
  localparam logic [6:0]  BRAKE_DUTY  = 7'd99;
  localparam logic [6:0]  MAX_DUTY    = 7'd100;

endpackage

// ===== hw/rtl/qwsc_serial_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand by unsigned multiplier.
module qwsc_serial_mul (
  input  logic              clk,
  input  logic              rst,
  input  qwsc_pkg::mul_req_t req,
  output qwsc_pkg::mul_rsp_t rsp
);
  import qwsc_pkg::*;

  localparam int CNT_W = $clog2(MP_W);

  logic signed [MC_W:0]   hi;
  logic [MP_W-1:0]        lo;
  logic signed [MC_W-1:0] mc;
  logic [CNT_W-1:0]       cnt;
  logic                   run;
  logic                   done;
  logic signed [MC_W:0]   addend;
  logic signed [MC_W:0]   sum;

  // One multiplier bit a cycle: add, then shift the partial product right
  assign addend = lo[0] ? {mc[MC_W-1], mc} : '0;
  assign sum    = hi + addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MP_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hi <= '0;
      lo <= req.mplier;
      mc <= req.mcand;
    end else if (run) begin
      hi <= sum >>> 1;
      lo <= {sum[0], lo[MP_W-1:1]};
    end
  end

  assign rsp.done = done;
  assign rsp.prod = {hi[MC_W-1:0], lo};

endmodule

// ===== hw/rtl/quadrature_wheel_speed_controller.sv =====
// Quadrature wheel speed controller for one wheel: encoder count, speed, cascaded P law.
//
// One item is taken at a time and every item gives exactly one result. An encoder
// edge, a distance read or an unused op code goes straight to the done state, where
// its result is loaded into the result register and handed over; the next item is
// taken once the block is back in idle. A control tick first folds the count into
// distance and the speed window, then the three products of the cascaded law (target
// by scale, speed error by its gain, acceleration error by its gain) are formed in
// turn in one shared shift-add multiplier that retires one bit of the 16-bit Q8.8
// gain per cycle; after that the magnitude is taken, the drive is set, and the
// result register is loaded and handed over. The moving sum over WINDOW_LEN ticks is
// kept as an exact running total (add the newest doubled count, drop the oldest), so
// its cost does not grow with the window. The result register parts the two sides:
// a new item is taken while an earlier result still waits for its transfer.
// Configuration writes are always taken and must only be made while the block
// is idle.
module quadrature_wheel_speed_controller #(
  parameter int WINDOW_LEN = 5
) (
  input  logic              clk,
  input  logic              rst,
  // input items
  input  logic              item_valid,
  output logic              item_stall,
  input  qwsc_pkg::item_t   item,
  // result items
  output logic              result_valid,
  input  logic              result_stall,
  output qwsc_pkg::result_t result,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import qwsc_pkg::*;

  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  // Exact window total: 18-bit entries plus growth, never narrower than the output
  localparam int TOT_W = 21 + $clog2(WINDOW_LEN);
  localparam logic signed [TOT_W-1:0] TOT_MAX = TOT_W'(SUM_MAX);
  localparam logic signed [TOT_W-1:0] TOT_MIN = TOT_W'(SUM_MIN);

  // Configuration registers
  logic [15:0] speed_scale;
  logic [15:0] speed_loop_gain;
  logic [15:0] accel_error_gain;

  // Encoder state
  logic signed [15:0] edge_count;
  logic               level_a;
  logic               level_b;
  logic [1:0]         last_line;

  // Speed window
  logic signed [17:0]      speed_history [WINDOW_LEN];
  logic [IDX_W-1:0]        history_index;
  logic signed [TOT_W-1:0] window_total;
  logic signed [19:0]      speed_sum;
  logic signed [19:0]      previous_speed;
  logic signed [20:0]      accel;
  logic [31:0]             distance_total;

  // Drive state
  logic       drv_fwd;
  logic       drv_rev;
  logic [6:0] drv_duty;

  // Per-item working registers
  logic signed [7:0]  target;
  logic [31:0]        res_dist;
  logic               cmd_neg;
  logic [39:0]        cmd_mag;

  state_t state, state_next;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic                    item_xfer;
  logic                    result_free;
  logic                    count_up;
  logic signed [17:0]      twice;
  logic signed [TOT_W-1:0] total_next;
  logic signed [19:0]      sum_sat;
  logic [PROD_W-1:0]       prod_abs;

  qwsc_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign cfg_ready   = 1'b1;
  assign item_xfer   = item_valid && !item_stall;
  assign result_free = !result_valid || !result_stall;

  // Line A counts up when it now matches B; line B counts up when it now differs from A
  assign count_up = item.encoder_line ? (item.pin_level != level_a)
                                      : (item.pin_level == level_b);

  assign twice      = {edge_count[15], edge_count, 1'b0};
  assign total_next = window_total
                    - {{(TOT_W-18){speed_history[history_index][17]}},
                       speed_history[history_index]}
                    + {{(TOT_W-18){twice[17]}}, twice};

  always_comb begin
    if (window_total > TOT_MAX) begin
      sum_sat = 20'(TOT_MAX);
    end else if (window_total < TOT_MIN) begin
      sum_sat = 20'(TOT_MIN);
    end else begin
      sum_sat = window_total[19:0];
    end
  end

  assign prod_abs = mul_rsp.prod[PROD_W-1] ? (PROD_W'(0) - mul_rsp.prod) : mul_rsp.prod;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and multiplier launch
  always_comb begin
    state_next     = state;
    item_stall     = 1'b1;
    mul_req.start  = 1'b0;
    mul_req.mcand  = '0;
    mul_req.mplier = '0;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (item.op == OP_TICK) begin
            state_next = ST_SUM;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SUM: begin
        state_next = ST_SAT;
      end
      ST_SAT: begin
        // target times scale
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{(MC_W-8){target[7]}}, target};
        mul_req.mplier = speed_scale;
        state_next     = ST_MUL1;
      end
      ST_MUL1: begin
        if (mul_rsp.done) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        // speed error in Q8 times its gain
        mul_req.start  = 1'b1;
        mul_req.mcand  = mul_rsp.prod[MC_W-1:0]
                       - {{(MC_W-28){speed_sum[19]}}, speed_sum, 8'b0};
        mul_req.mplier = speed_loop_gain;
        state_next     = ST_MUL2;
      end
      ST_MUL2: begin
        if (mul_rsp.done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        // acceleration error in Q16 times its gain
        mul_req.start  = 1'b1;
        mul_req.mcand  = mul_rsp.prod[MC_W-1:0]
                       - {{(MC_W-37){accel[20]}}, accel, 16'b0};
        mul_req.mplier = accel_error_gain;
        state_next     = ST_MUL3;
      end
      ST_MUL3: begin
        if (mul_rsp.done) begin
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        state_next = ST_DRV;
      end
      ST_DRV: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (result_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale      <= SPEED_SCALE_RST;
      speed_loop_gain  <= SPEED_LOOP_GAIN_RST;
      accel_error_gain <= ACCEL_ERROR_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SPEED_SCALE:      speed_scale      <= cfg_data;
        REG_SPEED_LOOP_GAIN:  speed_loop_gain  <= cfg_data;
        REG_ACCEL_ERROR_GAIN: accel_error_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count     <= '0;
      level_a        <= 1'b0;
      level_b        <= 1'b0;
      last_line      <= 2'd2;
      history_index  <= '0;
      window_total   <= '0;
      speed_sum      <= '0;
      previous_speed <= '0;
      distance_total <= '0;
      drv_fwd        <= 1'b0;
      drv_rev        <= 1'b0;
      drv_duty       <= MAX_DUTY;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        speed_history[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_xfer && item.op == OP_EDGE
              && last_line != {1'b0, item.encoder_line}) begin
            last_line <= {1'b0, item.encoder_line};
            if (item.encoder_line) begin
              level_b <= item.pin_level;
            end else begin
              level_a <= item.pin_level;
            end
            if (count_up && edge_count != 16'sh7fff) begin
              edge_count <= edge_count + 16'sd1;
            end else if (!count_up && edge_count != -16'sh8000) begin
              edge_count <= edge_count - 16'sd1;
            end
          end
          if (item_xfer && item.op == OP_READ) begin
            distance_total <= '0;
          end
        end
        ST_SUM: begin
          // fold the count into distance and the window, then clear it
          distance_total <= distance_total + {{16{edge_count[15]}}, edge_count};
          speed_history[history_index] <= twice;
          window_total <= total_next;
          if (history_index == IDX_W'(WINDOW_LEN - 1)) begin
            history_index <= '0;
          end else begin
            history_index <= history_index + 1'b1;
          end
          edge_count <= '0;
        end
        ST_SAT: begin
          speed_sum      <= sum_sat;
          previous_speed <= sum_sat;
        end
        ST_DRV: begin
          if (cmd_mag <= BRAKE_LIMIT) begin
            drv_fwd  <= 1'b1;
            drv_rev  <= 1'b1;
            drv_duty <= BRAKE_DUTY;
          end else begin
            drv_fwd  <= !cmd_neg;
            drv_rev  <= cmd_neg;
            drv_duty <= (cmd_mag > MAX_DUTY_W) ? MAX_DUTY : cmd_mag[6:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        res_dist <= distance_total;
        if (item.target_speed > TARGET_MAX) begin
          target <= TARGET_MAX;
        end else if (item.target_speed < TARGET_MIN) begin
          target <= TARGET_MIN;
        end else begin
          target <= item.target_speed;
        end
      end
      ST_SUM: begin
        res_dist <= distance_total + {{16{edge_count[15]}}, edge_count};
      end
      ST_SAT: begin
        accel <= {sum_sat[19], sum_sat} - {previous_speed[19], previous_speed};
      end
      ST_MAG: begin
        cmd_neg <= mul_rsp.prod[PROD_W-1];
        cmd_mag <= prod_abs[PROD_W-1:24];
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && result_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && result_free) begin
      result.measured_speed <= speed_sum;
      result.distance       <= res_dist;
      result.drive_forward  <= drv_fwd;
      result.drive_reverse  <= drv_rev;
      result.duty_percent   <= drv_duty;
    end
  end

endmodule
